### hw/rtl/sfpd_pkg.sv
// Package: constants, types and helpers shared across the sensor frame parser.
`default_nettype none
package sfpd_pkg;

   localparam int FRAME_LEN = 16;

   // Only bytes 0..10 feed the decoder; the last byte is checked on arrival.
   localparam int STORE_N   = 11;
   localparam int STORE_W   = $clog2(STORE_N);
   localparam int CNT_W     = $clog2(FRAME_LEN);

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

   localparam logic [7:0]  TYPE_SAMPLE = 8'h01;
   localparam logic [15:0] MILLI_PER_DEG = 16'd1000;
   localparam logic [15:0] MILLI_PER_TENTH_STEP = 16'd100;

   // x / 10 for x < 1029 as (x * 205) >> 11
   localparam logic [15:0] DIV10_MUL   = 16'd205;
   localparam int          DIV10_SHIFT = 11;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD = 1'b0,
      CSR_TAIL = 1'b1
   } csr_idx_type;

   typedef logic [STORE_N-1:0][7:0] frame_bytes_type;

   typedef struct packed {
      logic [7:0]  frame_type;
      logic        sample_valid;
      logic [15:0] formaldehyde;
      logic [15:0] temperature_milli;
      logic [7:0]  humidity_whole;
      logic [4:0]  humidity_tenth;
      logic [15:0] pm25;
   } rsp_type;

   function automatic logic [4:0] div10(input logic [7:0] x);
      logic [15:0] prod;
      prod = {8'd0, x} * DIV10_MUL;
      return prod[DIV10_SHIFT +: 5];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sfpd_if.sv
// Interfaces: byte request channel and decoded result channel.
`default_nettype none
interface sfpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_type;
   logic        sample_valid;
   logic [15:0] formaldehyde;
   logic [15:0] temperature_milli;
   logic [7:0]  humidity_whole;
   logic [4:0]  humidity_tenth;
   logic [15:0] pm25;

   modport source (output valid, output frame_type, output sample_valid,
                   output formaldehyde, output temperature_milli,
                   output humidity_whole, output humidity_tenth, output pm25,
                   input ready);
   modport sink   (input valid, input frame_type, input sample_valid,
                   input formaldehyde, input temperature_milli,
                   input humidity_whole, input humidity_tenth, input pm25,
                   output ready);
endinterface
`default_nettype wire

### hw/rtl/sfpd_framer.sv
// Frame tracker: head hunt, byte store, count and tail check.
`default_nettype none
module sfpd_framer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     beat,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [7:0]               head_byte,
   input  wire logic [7:0]               tail_byte,
   output      logic                     frame_done,
   output      sfpd_pkg::frame_bytes_type frame_bytes
);
   import sfpd_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   frame_bytes_type  store_ff, store_in;
   logic             is_head;

   assign is_head = (rx_byte == head_byte);

   always_comb begin
      count_in   = count_ff;
      store_in   = store_ff;
      frame_done = 1'b0;
      if (beat) begin
         if (count_ff == '0) begin
            if (is_head) begin
               store_in[0] = rx_byte;
               count_in    = CNT_W'(1);
            end
         end else if (count_ff == LAST_POS) begin
            if (rx_byte == tail_byte) begin
               frame_done = 1'b1;
               count_in   = '0;
            end else if (is_head) begin
               // bad tail, but the final byte opens a new frame
               store_in[0] = rx_byte;
               count_in    = CNT_W'(1);
            end else begin
               count_in = '0;
            end
         end else begin
            if (count_ff < CNT_W'(STORE_N)) begin
               store_in[count_ff[STORE_W-1:0]] = rx_byte;
            end
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   assign frame_bytes = store_ff;

endmodule
`default_nettype wire

### hw/rtl/sfpd_decode.sv
// Sample decoder: turns the held frame bytes into one result.
`default_nettype none
module sfpd_decode (
   input  wire sfpd_pkg::frame_bytes_type frame_bytes,
   input  wire logic [7:0]                head_byte,
   output      sfpd_pkg::rsp_type         rsp
);
   import sfpd_pkg::*;

   logic        valid;
   logic [15:0] deg_part;
   logic [15:0] tenth_part;

   assign valid = (frame_bytes[1] == TYPE_SAMPLE) && (frame_bytes[0] == head_byte);

   // wraps modulo 2^16
   assign deg_part   = {8'd0, frame_bytes[5]} * MILLI_PER_DEG;
   assign tenth_part = {11'd0, div10(frame_bytes[6])} * MILLI_PER_TENTH_STEP;

   always_comb begin
      rsp              = '0;
      rsp.frame_type   = frame_bytes[1];
      rsp.sample_valid = valid;
      if (valid) begin
         rsp.formaldehyde      = {frame_bytes[2], frame_bytes[3]};
         rsp.temperature_milli = deg_part + tenth_part;
         rsp.humidity_whole    = frame_bytes[7];
         rsp.humidity_tenth    = div10(frame_bytes[8]);
         rsp.pm25              = {frame_bytes[9], frame_bytes[10]};
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sfpd_rsp_queue.sv
// Two-entry result queue between the decoder and the result channel.
`default_nettype none
module sfpd_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfpd_pkg::rsp_type push_data,
   output      logic              full,
   output      logic              pop_valid,
   input  wire logic              pop_ready,
   output      sfpd_pkg::rsp_type pop_data
);
   import sfpd_pkg::*;

   rsp_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        pop;

   assign full      = (fill_ff == 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sensor_frame_parse_decode.sv
// Sensor frame parser top: a byte a cycle in unless stalled, one result per good frame.
// Each result enters the queue on its tail byte's beat and is then offered on rsp.
// Throughput: one byte beat per cycle, stalled while the result queue is full.
// A 2-entry result queue lets bytes keep flowing while a result waits on rsp.
// Reset (synchronous, high): clears byte count, head/tail registers and queue.
`default_nettype none
module sensor_frame_parse_decode (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sfpd_req_if.sink                            req_bus,
   sfpd_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [sfpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata
);
   import sfpd_pkg::*;

   // config registers
   logic [7:0] head_ff, head_in;
   logic [7:0] tail_ff, tail_in;

   logic            req_beat;
   logic            frame_done;
   frame_bytes_type frame_bytes;
   rsp_type         dec_rsp;
   rsp_type         out_rsp;
   logic            q_full;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_HEAD: head_in = csr_wdata;
            CSR_TAIL: tail_in = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // a byte is only taken when a result slot is free, as any beat may finish a frame
   assign req_bus.ready = ~q_full;
   assign req_beat      = req_bus.valid && ~q_full;

   sfpd_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .beat        (req_beat),
      .rx_byte     (req_bus.rx_byte),
      .head_byte   (head_ff),
      .tail_byte   (tail_ff),
      .frame_done  (frame_done),
      .frame_bytes (frame_bytes)
   );

   // bytes 0..10 are already held when the tail beat arrives
   sfpd_decode u_decode (
      .frame_bytes (frame_bytes),
      .head_byte   (head_ff),
      .rsp         (dec_rsp)
   );

   sfpd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_done),
      .push_data (dec_rsp),
      .full      (q_full),
      .pop_valid (rsp_bus.valid),
      .pop_ready (rsp_bus.ready),
      .pop_data  (out_rsp)
   );

   assign rsp_bus.frame_type        = out_rsp.frame_type;
   assign rsp_bus.sample_valid      = out_rsp.sample_valid;
   assign rsp_bus.formaldehyde      = out_rsp.formaldehyde;
   assign rsp_bus.temperature_milli = out_rsp.temperature_milli;
   assign rsp_bus.humidity_whole    = out_rsp.humidity_whole;
   assign rsp_bus.humidity_tenth    = out_rsp.humidity_tenth;
   assign rsp_bus.pm25              = out_rsp.pm25;

endmodule
`default_nettype wire

### dv/tb_sensor_frame_parse_decode.sv
// Testbench: byte beats into the sensor frame parser, each decoded result checked against a local model.
module tb_sensor_frame_parse_decode;
   import sfpd_pkg::*;

   // Upper bound of the random byte gap / receiver stall drawn per beat.
   localparam int MAX_GAP        = 16;
   // Spare wait that covers the result landing on rsp after the tail beat.
   localparam int SETTLE_CYCLES  = 4;
   // Long receiver hold-off, so the result queue fills and req stalls.
   localparam int HOLD_CYCLES    = 300;
   // Cycles with no beat and no register write before we give up.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_BYTES   = 860;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_wr_en = 1'b0;
   csr_idx_type csr_index = CSR_HEAD;
   logic [7:0]  csr_wdata = 8'h00;

   sfpd_req_if req_if();
   sfpd_rsp_if rsp_if();

   sensor_frame_parse_decode u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the parser: candidate bytes, fill count and the registers.
   // Updated only at reset and at edges where a beat or a register write really happens.
   // ------------------------------------------------------------------
   logic [7:0]  shadow_frame [FRAME_LEN];
   int unsigned shadow_count;
   logic [7:0]  shadow_head;
   logic [7:0]  shadow_tail;
   rsp_type     decoded_frames_q [$];

   // Stimulus side copy of the registers, used to build frames.
   logic [7:0]  cfg_head = 8'h00;
   logic [7:0]  cfg_tail = 8'h00;
   logic [7:0]  frame_buf [FRAME_LEN];

   int          error_count = 0;
   int          sent_bytes  = 0;
   int          quiet_cycles = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          hold_rsp    = 1'b0;

   // Advance the shadow parser by one byte; returns 1 when a frame completes
   // with a good tail, and then dec holds the decoded result.
   function automatic bit parse_byte(input logic [7:0] b, output rsp_type dec);
      int unsigned temp_milli;
      int unsigned tenth;
      bit          is_sample;
      dec = '0;
      // Hunting: only a head byte opens a candidate.
      if (shadow_count == 0) begin
         if (b == shadow_head) begin
            shadow_frame[0] = b;
            shadow_count    = 1;
         end
         return 1'b0;
      end
      shadow_frame[shadow_count] = b;
      shadow_count++;
      if (shadow_count < FRAME_LEN) begin
         return 1'b0;
      end
      shadow_count = 0;
      // Bad tail: drop, but a final byte equal to head opens a new candidate.
      if (b != shadow_tail) begin
         if (b == shadow_head) begin
            shadow_frame[0] = b;
            shadow_count    = 1;
         end
         return 1'b0;
      end
      // Byte 0 is checked against the head in force now, not when it came in.
      is_sample = (shadow_frame[1] == TYPE_SAMPLE) && (shadow_frame[0] == shadow_head);
      dec.frame_type   = shadow_frame[1];
      dec.sample_valid = is_sample;
      if (is_sample) begin
         temp_milli = int'(shadow_frame[5]) * 1000 + (int'(shadow_frame[6]) / 10) * 100;
         tenth      = int'(shadow_frame[8]) / 10;
         dec.formaldehyde      = {shadow_frame[2], shadow_frame[3]};
         dec.temperature_milli = temp_milli[15:0];
         dec.humidity_whole    = shadow_frame[7];
         dec.humidity_tenth    = tenth[4:0];
         dec.pm25              = {shadow_frame[9], shadow_frame[10]};
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // ------------------------------------------------------------------
   // Scoreboard. Everything is sampled at the edge, before any NBA lands,
   // so it sees exactly what the block saw. Byte beat first, then register
   // write, then result beat; a result never shares an edge with its tail.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type dec;
      rsp_type due;
      if (reset) begin
         shadow_count = 0;
         shadow_head  = 8'h00;
         shadow_tail  = 8'h00;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (parse_byte(req_if.rx_byte, dec)) begin
               decoded_frames_q.push_back(dec);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEAD: shadow_head = csr_wdata;
               CSR_TAIL: shadow_tail = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_frames_q.size() == 0) begin
               report_mismatch("result beat with nothing due, frame_type",
                               32'(rsp_if.frame_type), 0);
            end else begin
               due = decoded_frames_q.pop_front();
               check_field("frame_type", 32'(rsp_if.frame_type), 32'(due.frame_type));
               check_field("sample_valid", 32'(rsp_if.sample_valid),
                           32'(due.sample_valid));
               check_field("formaldehyde", 32'(rsp_if.formaldehyde),
                           32'(due.formaldehyde));
               check_field("temperature_milli", 32'(rsp_if.temperature_milli),
                           32'(due.temperature_milli));
               check_field("humidity_whole", 32'(rsp_if.humidity_whole),
                           32'(due.humidity_whole));
               check_field("humidity_tenth", 32'(rsp_if.humidity_tenth),
                           32'(due.humidity_tenth));
               check_field("pm25", 32'(rsp_if.pm25), 32'(due.pm25));
            end
         end
      end
   end

   // Watchdog: any beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: random stall before each beat, and on request one
   // long hold-off counted here, while the sender keeps pushing bytes.
   // ------------------------------------------------------------------
   initial begin
      int gap;
      int held;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               @(posedge clock);
            end
            hold_rsp = 1'b0;
         end
         gap = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Ready stays up across back-to-back beats when gap is 0.
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid && !hold_rsp);
      end
   end

   // ------------------------------------------------------------------
   // Byte sender helpers
   // ------------------------------------------------------------------

   // One byte beat. Valid is left high on return so that a zero gap keeps
   // it high into the next beat; anything else that spends time lowers it.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      sent_bytes++;
   endtask

   // Quiet the byte side and wait until every result has been taken,
   // plus the pipeline latency, so a register write lands on an idle block.
   // The first edge lets the scoreboard log a frame closed by the last beat.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (decoded_frames_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [7:0] val);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HEAD) begin
         cfg_head = val;
      end else begin
         cfg_tail = val;
      end
   endtask

   // Byte that neither opens a frame nor passes as a tail.
   function automatic logic [7:0] pick_filler();
      logic [7:0] v;
      do v = 8'($urandom); while (v == cfg_head || v == cfg_tail);
      return v;
   endfunction

   // Payload byte, leaning on the extremes now and then.
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void fill_frame(input logic [7:0] kind, input bit good_tail);
      logic [7:0] v;
      frame_buf[0] = cfg_head;
      frame_buf[1] = kind;
      for (int i = 2; i < FRAME_LEN - 1; i++) begin
         frame_buf[i] = pick_payload();
      end
      if (good_tail) begin
         frame_buf[FRAME_LEN-1] = cfg_tail;
      end else begin
         do v = 8'($urandom); while (v == cfg_tail);
         frame_buf[FRAME_LEN-1] = v;
      end
   endfunction

   task automatic send_span(input int lo, input int hi);
      for (int i = lo; i <= hi; i++) begin
         send_byte(frame_buf[i]);
      end
   endtask

   // Enough filler to close any open candidate with a bad tail and land
   // back in the hunt state (filler is never a head).
   task automatic resync();
      repeat (FRAME_LEN) send_byte(pick_filler());
   endtask

   function automatic logic [7:0] pick_kind();
      return ($urandom_range(0, 9) < 7) ? TYPE_SAMPLE : 8'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Head and tail both reset to 0: zero-delimited frames must decode.
   task automatic test_reset_values();
      send_byte(pick_filler());
      send_byte(pick_filler());
      fill_frame(TYPE_SAMPLE, 1'b1);
      send_span(0, FRAME_LEN - 1);
      fill_frame(8'h00, 1'b1);
      send_span(0, FRAME_LEN - 1);
   endtask

   // All-ones and all-zeros payloads: temperature wrap, tenth at its top,
   // the divide-by-ten boundary at 9 and 10, and the register extremes.
   task automatic test_sample_extremes();
      write_csr(CSR_HEAD, 8'hFF);
      write_csr(CSR_TAIL, 8'h00);
      fill_frame(TYPE_SAMPLE, 1'b1);
      for (int i = 2; i < FRAME_LEN - 1; i++) frame_buf[i] = 8'hFF;
      send_span(0, FRAME_LEN - 1);
      fill_frame(TYPE_SAMPLE, 1'b1);
      for (int i = 2; i < FRAME_LEN - 1; i++) frame_buf[i] = 8'h00;
      send_span(0, FRAME_LEN - 1);
      write_csr(CSR_HEAD, 8'h00);
      write_csr(CSR_TAIL, 8'hFF);
      fill_frame(TYPE_SAMPLE, 1'b1);
      for (int i = 2; i < FRAME_LEN - 1; i++) frame_buf[i] = (i % 2) ? 8'hA5 : 8'h5A;
      frame_buf[6] = 8'd9;
      frame_buf[8] = 8'd10;
      send_span(0, FRAME_LEN - 1);
   endtask

   // Non-sample types carry only the type, sample fields zeroed.
   task automatic test_frame_types();
      logic [7:0] kinds [4];
      kinds = '{8'h00, 8'h02, 8'h80, 8'hFF};
      write_csr(CSR_HEAD, 8'h5A);
      write_csr(CSR_TAIL, 8'hA5);
      foreach (kinds[k]) begin
         fill_frame(kinds[k], 1'b1);
         send_span(0, FRAME_LEN - 1);
      end
   endtask

   // Bad tails: plain drop, then a drop whose last byte is a head and so
   // opens the next frame; then head equal to tail, where a good tail
   // must not also reopen a candidate.
   task automatic test_bad_tail();
      fill_frame(TYPE_SAMPLE, 1'b0);
      frame_buf[FRAME_LEN-1] = pick_filler();
      send_span(0, FRAME_LEN - 1);
      send_byte(pick_filler());
      fill_frame(TYPE_SAMPLE, 1'b0);
      frame_buf[FRAME_LEN-1] = cfg_head;
      send_span(0, FRAME_LEN - 1);
      fill_frame(TYPE_SAMPLE, 1'b1);
      send_span(1, FRAME_LEN - 1);
      write_csr(CSR_TAIL, cfg_head);
      fill_frame(TYPE_SAMPLE, 1'b1);
      send_span(0, FRAME_LEN - 1);
      fill_frame(8'h07, 1'b1);
      send_span(0, FRAME_LEN - 1);
   endtask

   // Register changes with a candidate half built: a new head demotes the
   // frame to non-sample, a new tail is the one the last byte is held to.
   task automatic test_mid_frame_change();
      write_csr(CSR_HEAD, 8'h11);
      write_csr(CSR_TAIL, 8'h22);
      fill_frame(TYPE_SAMPLE, 1'b1);
      send_span(0, 7);
      write_csr(CSR_HEAD, 8'h33);
      send_span(8, FRAME_LEN - 1);
      fill_frame(TYPE_SAMPLE, 1'b1);
      send_span(0, 7);
      write_csr(CSR_TAIL, 8'h44);
      frame_buf[FRAME_LEN-1] = cfg_tail;
      send_span(8, FRAME_LEN - 1);
   endtask

   // Receiver holds off while good frames stream in back to back.
   task automatic test_back_pressure();
      req_idle_on = 1'b0;
      hold_rsp    = 1'b1;
      repeat (5) begin
         fill_frame(TYPE_SAMPLE, 1'b1);
         send_span(0, FRAME_LEN - 1);
      end
      settle();
      req_idle_on = 1'b1;
   endtask

   // New register pair and idle mix for a phase; extremes and head==tail
   // come up regularly.
   task automatic new_phase();
      logic [7:0] h;
      logic [7:0] t;
      case ($urandom_range(0, 5))
         0:       h = 8'h00;
         1:       h = 8'hFF;
         default: h = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       t = 8'h00;
         1:       t = 8'hFF;
         2:       t = h;
         default: t = 8'($urandom);
      endcase
      write_csr(CSR_HEAD, h);
      write_csr(CSR_TAIL, t);
      req_idle_on = ($urandom_range(0, 2) != 0);
      rsp_idle_on = ($urandom_range(0, 2) != 0);
   endtask

   // Mostly well-formed frames with random payload, plus bad tails (some
   // reopening on a head), register changes mid-frame, noise and cut-off
   // frames. When a bad tail reopens a candidate, the next frame goes on
   // from byte 1 so the stream stays aligned.
   task automatic test_random_traffic();
      int         start_bytes;
      int         frames_left;
      int         pick;
      int         lo;
      int         cut;
      bit         carry_head;
      bit         dirty;
      logic [7:0] v;
      start_bytes = sent_bytes;
      frames_left = 0;
      carry_head  = 1'b0;
      while (sent_bytes - start_bytes < RANDOM_BYTES) begin
         if (frames_left == 0) begin
            new_phase();
            frames_left = $urandom_range(4, 12);
         end
         lo   = carry_head ? 1 : 0;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            fill_frame(pick_kind(), 1'b1);
            send_span(lo, FRAME_LEN - 1);
            carry_head = 1'b0;
         end else if (pick < 82) begin
            fill_frame(pick_kind(), 1'b0);
            if (cfg_head != cfg_tail && $urandom_range(0, 1)) begin
               frame_buf[FRAME_LEN-1] = cfg_head;
            end
            send_span(lo, FRAME_LEN - 1);
            carry_head = (frame_buf[FRAME_LEN-1] == cfg_head);
         end else if (pick < 89) begin
            fill_frame(pick_kind(), 1'b1);
            cut = $urandom_range(lo + 1, FRAME_LEN - 1);
            send_span(lo, cut - 1);
            if ($urandom_range(0, 1)) begin
               write_csr(CSR_HEAD, 8'($urandom));
            end else begin
               write_csr(CSR_TAIL, 8'($urandom));
            end
            frame_buf[FRAME_LEN-1] = cfg_tail;
            send_span(cut, FRAME_LEN - 1);
            carry_head = 1'b0;
         end else if (pick < 95) begin
            // Noise, now and then with a stray head that needs flushing.
            dirty = carry_head;
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 7) == 0) begin
                  v = 8'($urandom);
                  if (v == cfg_head) dirty = 1'b1;
               end else begin
                  v = pick_filler();
               end
               send_byte(v);
            end
            if (dirty) resync();
            carry_head = 1'b0;
         end else begin
            fill_frame(pick_kind(), 1'b1);
            send_span(lo, $urandom_range(lo, FRAME_LEN - 3));
            resync();
            carry_head = 1'b0;
         end
         frames_left--;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_sample_extremes();
      test_frame_types();
      test_bad_tail();
      test_mid_frame_change();
      test_back_pressure();
      test_random_traffic();

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decoded_frames_q.size() != 0) begin
         report_mismatch("results never delivered, count", decoded_frames_q.size(), 0);
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
